// ===== hw/rtl/sfr_pkg.sv =====
package sfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CfgIdxW = 3;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_FLAG        = 3'd0,
    REG_ESCAPE      = 3'd1,
    REG_ESC_FLAG    = 3'd2,
    REG_ESC_ESCAPE  = 3'd3,
    REG_SENDER_ADDR = 3'd4,
    REG_CTRL_SEQ0   = 3'd5,
    REG_CTRL_SEQ1   = 3'd6
  } reg_idx_e;

  localparam logic [ByteW-1:0] FlagRst       = 8'h7E;
  localparam logic [ByteW-1:0] EscapeRst     = 8'h7D;
  localparam logic [ByteW-1:0] EscFlagRst    = 8'h5E;
  localparam logic [ByteW-1:0] EscEscapeRst  = 8'h5D;
  localparam logic [ByteW-1:0] SenderAddrRst = 8'h03;
  localparam logic [ByteW-1:0] CtrlSeq0Rst   = 8'h00;
  localparam logic [ByteW-1:0] CtrlSeq1Rst   = 8'h40;

  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REJECT  = 2'd2,
    KIND_DUP     = 2'd3
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0] flag;
    logic [ByteW-1:0] escape;
    logic [ByteW-1:0] esc_flag;
    logic [ByteW-1:0] esc_escape;
    logic [ByteW-1:0] sender_addr;
    logic [ByteW-1:0] ctrl_seq0;
    logic [ByteW-1:0] ctrl_seq1;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic             seq;
  } result_t;

endpackage

// ===== hw/rtl/sfr_parser.sv =====
// Frame parser: one byte per step, at most one result per step.
module sfr_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [sfr_pkg::ByteW-1:0]    byte_i,
  input  sfr_pkg::cfg_t                cfg_i,
  output sfr_pkg::result_t             res_o
);

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_FLAG = 6'b000010,
    PH_ADDR = 6'b000100,
    PH_CTRL = 6'b001000,
    PH_DATA = 6'b010000,
    PH_ESC  = 6'b100000
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic                        exp_seq_q, exp_seq_d;
  logic                        frm_seq_q, frm_seq_d;
  logic                        held_valid_q, held_valid_d;
  logic [sfr_pkg::ByteW-1:0]   held_byte_q, held_byte_d;
  logic [sfr_pkg::ByteW-1:0]   xor_q, xor_d;

  logic                        take;
  logic [sfr_pkg::ByteW-1:0]   take_byte;
  logic                        close;
  logic [sfr_pkg::ByteW-1:0]   ctl_sel;
  logic                        in_sync;

  assign in_sync = (frm_seq_q == exp_seq_q);
  assign ctl_sel = frm_seq_q ? cfg_i.ctrl_seq1 : cfg_i.ctrl_seq0;

  // Phase decode
  always_comb begin
    phase_d   = phase_q;
    frm_seq_d = frm_seq_q;
    take      = 1'b0;
    take_byte = byte_i;
    close     = 1'b0;
    unique case (phase_q)
      PH_HUNT: begin
        if (byte_i == cfg_i.flag) phase_d = PH_FLAG;
      end
      PH_FLAG: begin
        if (byte_i == cfg_i.sender_addr) phase_d = PH_ADDR;
        else if (byte_i != cfg_i.flag) phase_d = PH_HUNT;
      end
      PH_ADDR: begin
        priority if (byte_i == cfg_i.ctrl_seq0) begin
          frm_seq_d = 1'b0;
          phase_d   = PH_CTRL;
        end else if (byte_i == cfg_i.ctrl_seq1) begin
          frm_seq_d = 1'b1;
          phase_d   = PH_CTRL;
        end else if (byte_i == cfg_i.flag) begin
          phase_d = PH_FLAG;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_CTRL: begin
        // header check wins over a flag of the same value
        if (byte_i == (cfg_i.sender_addr ^ ctl_sel)) phase_d = PH_DATA;
        else if (byte_i == cfg_i.flag) phase_d = PH_FLAG;
        else phase_d = PH_HUNT;
      end
      PH_DATA: begin
        priority if (byte_i == cfg_i.escape) begin
          phase_d = PH_ESC;
        end else if (byte_i == cfg_i.flag) begin
          close   = 1'b1;
          phase_d = PH_HUNT;
        end else begin
          take = 1'b1;
        end
      end
      PH_ESC: begin
        phase_d = PH_DATA;
        priority if (byte_i == cfg_i.esc_flag) begin
          take      = 1'b1;
          take_byte = cfg_i.flag;
        end else if (byte_i == cfg_i.esc_escape) begin
          take      = 1'b1;
          take_byte = cfg_i.escape;
        end else begin
          // unknown code: the pair is dropped
          take = 1'b0;
        end
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  // Data path: one-byte holdback, running XOR, verdict
  always_comb begin
    exp_seq_d    = exp_seq_q;
    held_valid_d = held_valid_q;
    held_byte_d  = held_byte_q;
    xor_d        = xor_q;
    res_o        = '{valid: 1'b0, kind: sfr_pkg::KIND_PAYLOAD,
                     data: '0, seq: exp_seq_q};
    if (phase_q == PH_CTRL && phase_d == PH_DATA) begin
      held_valid_d = 1'b0;
      held_byte_d  = '0;
      xor_d        = '0;
    end
    if (take) begin
      if (held_valid_q && in_sync) begin
        xor_d       = xor_q ^ held_byte_q;
        res_o.valid = 1'b1;
        res_o.data  = held_byte_q;
      end
      held_byte_d  = take_byte;
      held_valid_d = 1'b1;
    end
    if (close) begin
      res_o.valid = 1'b1;
      priority if (!in_sync) begin
        res_o.kind = sfr_pkg::KIND_DUP;
      end else if (held_valid_q && held_byte_q == xor_q) begin
        exp_seq_d  = ~exp_seq_q;
        res_o.kind = sfr_pkg::KIND_ACCEPT;
      end else begin
        res_o.kind = sfr_pkg::KIND_REJECT;
      end
      res_o.seq    = exp_seq_d;
      held_valid_d = 1'b0;
      held_byte_d  = '0;
      xor_d        = '0;
    end
    if (!step_i) res_o.valid = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      exp_seq_q    <= 1'b0;
      frm_seq_q    <= 1'b0;
      held_valid_q <= 1'b0;
      held_byte_q  <= '0;
      xor_q        <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      exp_seq_q    <= exp_seq_d;
      frm_seq_q    <= frm_seq_d;
      held_valid_q <= held_valid_d;
      held_byte_q  <= held_byte_d;
      xor_q        <= xor_d;
    end
  end

  a_result_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (phase_q == PH_DATA || phase_q == PH_ESC))
    else $error("result outside payload phases");

  a_payload_in_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == sfr_pkg::KIND_PAYLOAD) |-> in_sync)
    else $error("payload emitted for duplicate frame");

  a_accept_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == sfr_pkg::KIND_ACCEPT) |=> exp_seq_q != $past(exp_seq_q))
    else $error("accepted frame did not toggle sequence");

  a_hunt_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HUNT) |-> !held_valid_q)
    else $error("held byte left over while hunting");

endmodule

// ===== hw/rtl/stuffed_frame_receiver.sv =====
// Channel   Dir  Signals                    Contents (low bit first)
// s_axis    in   tvalid/tready/tdata[7:0]   rx_byte
// m_axis    out  tvalid/tready/tdata[15:0]  payload_byte[7:0], ack_sequence[8], zero pad
//                tuser[1:0]                 out_kind
// cfg       in   cfg_we_i/cfg_idx_i/cfg_wdata_i, write-only, no wait
//
// One byte per cycle while the sink keeps up: the parser state updates in the cycle a byte
// is taken, and any result lands in the output register on the same edge.
// A byte is taken whenever the output register is empty or being drained, so a
// pending result never blocks the next transaction unless the sink stalls.
// Reset (async, active low) puts the parser in flag hunt, sequence 0, and the
// configuration registers at their defaults.
// Configuration is to be written only while no transaction is pending; the block
// does not enforce this. A write applies from the next byte on.
module stuffed_frame_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input byte stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // rx_byte
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,   // payload_byte, ack_sequence, pad
  output logic [1:0]                    m_axis_tuser,   // out_kind
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfr_pkg::ByteW-1:0]     cfg_wdata_i
);

  sfr_pkg::cfg_t    cfg_q;
  sfr_pkg::result_t res;

  logic                        in_xact;
  logic                        out_valid_q, out_valid_d;
  sfr_pkg::kind_e              out_kind_q;
  logic [sfr_pkg::ByteW-1:0]   out_data_q;
  logic                        out_seq_q;

  // Output register doubles as the decoupling stage: free when empty or draining.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xact       = s_axis_tvalid && s_axis_tready;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag        <= sfr_pkg::FlagRst;
      cfg_q.escape      <= sfr_pkg::EscapeRst;
      cfg_q.esc_flag    <= sfr_pkg::EscFlagRst;
      cfg_q.esc_escape  <= sfr_pkg::EscEscapeRst;
      cfg_q.sender_addr <= sfr_pkg::SenderAddrRst;
      cfg_q.ctrl_seq0   <= sfr_pkg::CtrlSeq0Rst;
      cfg_q.ctrl_seq1   <= sfr_pkg::CtrlSeq1Rst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfr_pkg::REG_FLAG:        cfg_q.flag        <= cfg_wdata_i;
        sfr_pkg::REG_ESCAPE:      cfg_q.escape      <= cfg_wdata_i;
        sfr_pkg::REG_ESC_FLAG:    cfg_q.esc_flag    <= cfg_wdata_i;
        sfr_pkg::REG_ESC_ESCAPE:  cfg_q.esc_escape  <= cfg_wdata_i;
        sfr_pkg::REG_SENDER_ADDR: cfg_q.sender_addr <= cfg_wdata_i;
        sfr_pkg::REG_CTRL_SEQ0:   cfg_q.ctrl_seq0   <= cfg_wdata_i;
        sfr_pkg::REG_CTRL_SEQ1:   cfg_q.ctrl_seq1   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sfr_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_xact),
    .byte_i (s_axis_tdata),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // A transaction always consumes the old result (ready implies drain), so the
  // new valid is simply whether this byte produced one.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xact) out_valid_d = res.valid;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload register: loaded only with a fresh result
  always_ff @(posedge clk_i) begin
    if (in_xact && res.valid) begin
      out_kind_q <= res.kind;
      out_data_q <= res.data;
      out_seq_q  <= res.seq;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_seq_q, out_data_q};
  assign m_axis_tuser  = out_kind_q;

endmodule

// ===== tb/sfr_frame_checker.sv =====
module sfr_frame_checker
  import sfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [7:0]         s_tdata_i,    // rx_byte
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [15:0]        m_tdata_i,    // payload_byte[7:0], ack_sequence[8], zero pad
  input  logic [1:0]         m_tuser_i,    // out_kind
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  input  logic               end_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef enum logic [2:0] {
    HUNT_FLAG,
    SEEN_FLAG,
    SEEN_ADDR,
    SEEN_CTRL,
    IN_PAYLOAD,
    AFTER_ESC
  } parse_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       seq;
  } frame_out_t;

  cfg_t       regs;
  parse_e     phase;
  logic       exp_seq;
  logic       frame_seq;
  logic       held_vld;
  logic [7:0] held_q;
  logic [7:0] acc_xor;
  frame_out_t predicted_outputs[$];
  int         errors = 0;
  bit         ended = 1'b0;

  function automatic void push_out(kind_e k, logic [7:0] d);
    frame_out_t r;
    r.kind = k;
    r.data = d;
    r.seq  = exp_seq;
    predicted_outputs.push_back(r);
  endfunction

  // Payload goes out one byte late; the byte still held at the closing flag is BCC2.
  function automatic void take_payload(logic [7:0] d);
    if (held_vld && frame_seq == exp_seq) begin
      acc_xor = acc_xor ^ held_q;
      push_out(KIND_PAYLOAD, held_q);
    end
    held_q   = d;
    held_vld = 1'b1;
  endfunction

  function automatic void settle_frame();
    kind_e k;
    if (frame_seq != exp_seq) begin
      k = KIND_DUP;
    end else if (held_vld && held_q == acc_xor) begin
      exp_seq = ~exp_seq;
      k = KIND_ACCEPT;
    end else begin
      k = KIND_REJECT;
    end
    phase    = HUNT_FLAG;
    held_vld = 1'b0;
    held_q   = '0;
    acc_xor  = '0;
    push_out(k, '0);
  endfunction

  function automatic void parse_line_byte(logic [7:0] b);
    logic [7:0] ctl;
    case (phase)
      HUNT_FLAG: begin
        if (b == regs.flag) phase = SEEN_FLAG;
      end
      SEEN_FLAG: begin
        if (b == regs.sender_addr) phase = SEEN_ADDR;
        else if (b != regs.flag) phase = HUNT_FLAG;
      end
      SEEN_ADDR: begin
        // a byte matching both control values means sequence 0
        if (b == regs.ctrl_seq0 || b == regs.ctrl_seq1) begin
          frame_seq = (b != regs.ctrl_seq0);
          phase = SEEN_CTRL;
        end else if (b == regs.flag) begin
          phase = SEEN_FLAG;
        end else begin
          phase = HUNT_FLAG;
        end
      end
      SEEN_CTRL: begin
        ctl = frame_seq ? regs.ctrl_seq1 : regs.ctrl_seq0;
        if (b == (regs.sender_addr ^ ctl)) begin
          phase    = IN_PAYLOAD;
          held_vld = 1'b0;
          held_q   = '0;
          acc_xor  = '0;
        end else if (b == regs.flag) begin
          phase = SEEN_FLAG;
        end else begin
          phase = HUNT_FLAG;
        end
      end
      IN_PAYLOAD: begin
        if (b == regs.escape) phase = AFTER_ESC;
        else if (b == regs.flag) settle_frame();
        else take_payload(b);
      end
      AFTER_ESC: begin
        phase = IN_PAYLOAD;
        if (b == regs.esc_flag) take_payload(regs.flag);
        else if (b == regs.esc_escape) take_payload(regs.escape);
      end
      default: begin
        phase = HUNT_FLAG;
      end
    endcase
  endfunction

  function automatic void check_field(string what, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want_v, got_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_out_t want;
    if (!rst_ni) begin
      regs = '{FlagRst, EscapeRst, EscFlagRst, EscEscapeRst,
               SenderAddrRst, CtrlSeq0Rst, CtrlSeq1Rst};
      phase     = HUNT_FLAG;
      exp_seq   = 1'b0;
      frame_seq = 1'b0;
      held_vld  = 1'b0;
      held_q    = '0;
      acc_xor   = '0;
      predicted_outputs.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // output side first: a result taken now was predicted at an earlier edge
      if (m_tvalid_i && m_tready_i) begin
        if (predicted_outputs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none got kind %0h data %0h",
                   $time, m_tuser_i, m_tdata_i);
        end else begin
          want = predicted_outputs.pop_front();
          check_field("out_kind", {6'b0, want.kind}, {6'b0, m_tuser_i});
          check_field("payload_byte", want.data, m_tdata_i[7:0]);
          check_field("ack_sequence", {7'b0, want.seq}, {7'b0, m_tdata_i[8]});
          check_field("tdata pad", 8'h00, {1'b0, m_tdata_i[15:9]});
        end
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_FLAG:        regs.flag        = cfg_wdata_i;
          REG_ESCAPE:      regs.escape      = cfg_wdata_i;
          REG_ESC_FLAG:    regs.esc_flag    = cfg_wdata_i;
          REG_ESC_ESCAPE:  regs.esc_escape  = cfg_wdata_i;
          REG_SENDER_ADDR: regs.sender_addr = cfg_wdata_i;
          REG_CTRL_SEQ0:   regs.ctrl_seq0   = cfg_wdata_i;
          REG_CTRL_SEQ1:   regs.ctrl_seq1   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) parse_line_byte(s_tdata_i);
      if (end_i && !ended) begin
        ended = 1'b1;
        if (predicted_outputs.size() != 0) begin
          $display("%0t: missing results, expected %0d more got 0", $time,
                   predicted_outputs.size());
          errors += predicted_outputs.size();
        end
      end
      pending_o    <= predicted_outputs.size();
      fail_count_o <= errors;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Stimulus and verdict for the byte-stuffed frame receiver. The checker beside
// the block predicts every result from the line bytes it sees accepted; this
// module only makes traffic, moves through the configuration phases and reads
// the failure count at the end.
module testbench;
  import sfr_pkg::*;

  // --------------------------------------------------------------------------
  // Clock, reset and block-facing signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = '0;     // rx_byte
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;          // payload_byte[7:0], ack_sequence[8], zero pad
  logic [1:0]         m_axis_tuser;          // out_kind
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [ByteW-1:0]   cfg_wdata_i = '0;

  logic       end_check = 1'b0;
  int         fail_count;
  int         pending;

  // Idle/stall odds in percent, changed only between phases
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;

  // Stimulus-side copy of the registers, needed to build well-formed frames
  cfg_t       line_cfg;
  logic [7:0] line_q[$];
  int         phase_sent;

  always #1 clk_i = ~clk_i;

  stuffed_frame_receiver dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  sfr_frame_checker u_checker (
    .clk_i,
    .rst_ni,
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .end_i        (end_check),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Result sink: ready is re-rolled every cycle, so stalls land on any phase
  // of a frame, including verdict transactions.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Hard stop; the slowest correct run needs a small fraction of this
  initial begin
    #2000000;
    $display("stuffed_frame_receiver regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Line-side driver
  // --------------------------------------------------------------------------

  // One line byte, with random idle cycles ahead of it. Returns right after
  // the edge that completed the transaction.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    phase_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  // Stop sending and wait for the checker to have nothing outstanding.
  // The first edge lets the pending count catch up with the last transaction.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Leaves the write enable high; load_cfg lowers it after the last register
  task automatic write_reg(input reg_idx_e idx, input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
  endtask

  // Only called with the block idle (after reset or after settle)
  task automatic load_cfg(input cfg_t c);
    write_reg(REG_FLAG, c.flag);
    write_reg(REG_ESCAPE, c.escape);
    write_reg(REG_ESC_FLAG, c.esc_flag);
    write_reg(REG_ESC_ESCAPE, c.esc_escape);
    write_reg(REG_SENDER_ADDR, c.sender_addr);
    write_reg(REG_CTRL_SEQ0, c.ctrl_seq0);
    write_reg(REG_CTRL_SEQ1, c.ctrl_seq1);
    cfg_we_i <= 1'b0;
    line_cfg = c;
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.flag        = 8'($urandom);
    c.escape      = 8'($urandom);
    c.esc_flag    = 8'($urandom);
    c.esc_escape  = 8'($urandom);
    c.sender_addr = 8'($urandom);
    c.ctrl_seq0   = 8'($urandom);
    c.ctrl_seq1   = 8'($urandom);
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Frame builders (append to line_q)
  // --------------------------------------------------------------------------

  // Byte stuffing as the sender would do it; the flag meaning wins when the
  // flag and escape values coincide.
  function automatic void push_stuffed(input logic [7:0] d);
    if (d == line_cfg.flag) begin
      line_q.push_back(line_cfg.escape);
      line_q.push_back(line_cfg.esc_flag);
    end else if (d == line_cfg.escape) begin
      line_q.push_back(line_cfg.escape);
      line_q.push_back(line_cfg.esc_escape);
    end else begin
      line_q.push_back(d);
    end
  endfunction

  // Information frame with random sequence and payload. Most are clean; some
  // carry an unknown escape pair or a corrupted BCC2, some have no payload.
  function automatic void build_frame();
    logic       seq_bit;
    logic [7:0] ctl;
    logic [7:0] bcc;
    logic [7:0] d;
    int         len;
    seq_bit = 1'($urandom_range(1));
    ctl = seq_bit ? line_cfg.ctrl_seq1 : line_cfg.ctrl_seq0;
    line_q.push_back(line_cfg.flag);
    line_q.push_back(line_cfg.sender_addr);
    line_q.push_back(ctl);
    line_q.push_back(line_cfg.sender_addr ^ ctl);
    // mostly short payloads, now and then a long one
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6);
    bcc = '0;
    repeat (len) begin
      case ($urandom_range(7))
        0:       d = line_cfg.flag;
        1:       d = line_cfg.escape;
        default: d = 8'($urandom);
      endcase
      bcc = bcc ^ d;
      push_stuffed(d);
      if ($urandom_range(24) == 0) begin
        // escape followed by a code that means nothing: pair is dropped
        line_q.push_back(line_cfg.escape);
        do d = 8'($urandom); while (d == line_cfg.esc_flag || d == line_cfg.esc_escape);
        line_q.push_back(d);
      end
    end
    if ($urandom_range(7) == 0) bcc = bcc ^ (8'h01 << $urandom_range(7));
    // with no payload, half the frames still carry a BCC2 byte, half are empty
    if (len != 0 || $urandom_range(1) != 0) push_stuffed(bcc);
    line_q.push_back(line_cfg.flag);
  endfunction

  // Broken headers and plain line noise
  function automatic void build_noise();
    if ($urandom_range(1) != 0) begin
      line_q.push_back(line_cfg.flag);
      if ($urandom_range(1) != 0) line_q.push_back(line_cfg.sender_addr);
      if ($urandom_range(1) != 0) begin
        line_q.push_back($urandom_range(1) ? line_cfg.ctrl_seq1 : line_cfg.ctrl_seq0);
      end
      line_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(4, 1)) line_q.push_back(8'($urandom));
    end
  endfunction

  // Random traffic until about n line bytes went through; optionally the
  // sender holds off halfway until every expected result has been taken.
  task automatic random_phase(input int n, input bit pause_midway);
    bit paused;
    paused = 1'b0;
    phase_sent = 0;
    while (phase_sent < n) begin
      if (pause_midway && !paused && phase_sent >= n / 2) begin
        paused = 1'b1;
        settle();
      end
      if ($urandom_range(99) < 80) build_frame();
      else build_noise();
      send_line();
    end
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    line_cfg = '{FlagRst, EscapeRst, EscFlagRst, EscEscapeRst,
                 SenderAddrRst, CtrlSeq0Rst, CtrlSeq1Rst};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset values (flag 7E, escape 7D, addr 03, ctrl 00/40)
    line_q = '{
      8'h7E, 8'h99,                        // flag then junk: back to hunting
      // seq 0 frame, payload 7E 7D FF stuffed, one unknown escape pair,
      // BCC2 = 7E^7D^FF = FC -> accepted, expected sequence toggles to 1
      8'h7E, 8'h03, 8'h00, 8'h03,
      8'h7D, 8'h5E, 8'h7D, 8'h5D, 8'h7D, 8'h11, 8'hFF, 8'hFC, 8'h7E,
      // seq 0 again: duplicate, no payload
      8'h7E, 8'h03, 8'h00, 8'h03, 8'h7E,
      // header abandoned by a flag, then an empty seq 1 frame: rejected
      8'h7E, 8'h03, 8'h7E, 8'h03, 8'h40, 8'h43, 8'h7E
    };
    send_line();
    settle();

    // Defaults, no idling on either side
    random_phase(350, 1'b0);

    // Random registers, sender mostly idle
    src_idle_pct = 87;
    load_cfg(random_cfg());
    random_phase(260, 1'b0);

    // All-ones / all-zeros registers, receiver mostly stalled
    src_idle_pct   = 0;
    sink_stall_pct = 87;
    load_cfg('{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});
    random_phase(200, 1'b0);

    // The opposite extremes, light idling on both sides
    src_idle_pct   = 18;
    sink_stall_pct = 18;
    load_cfg('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00});
    random_phase(200, 1'b0);

    // Equal control values (both decode as seq 0) and a header check that
    // equals the flag (2B ^ 55 = 7E); sender drains halfway through
    load_cfg('{8'h7E, 8'h7D, 8'h5E, 8'h5D, 8'h2B, 8'h55, 8'h55});
    random_phase(260, 1'b1);

    // Escape equal to flag: in payload the escape meaning wins, so frames
    // never close and only payload transactions come out
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    load_cfg('{8'h7E, 8'h7E, 8'h5E, 8'h5D, 8'h03, 8'h00, 8'h40});
    random_phase(100, 1'b0);

    // One more random setting at full rate
    load_cfg(random_cfg());
    random_phase(200, 1'b0);

    // Leftover expectations are counted by the checker once end_check is seen
    end_check <= 1'b1;
    repeat (3) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("stuffed_frame_receiver regression: pass");
    end else begin
      $display("stuffed_frame_receiver regression: fail");
    end
    $finish;
  end

endmodule
